[design/frb_pkg.sv]
package frb_pkg;

    localparam int ENTRIES_DEF   = 8;
    localparam int MSG_BYTES_DEF = 64;

    localparam logic [7:0] MARKER = 8'd127;

    localparam logic [1:0] CMD_SAVE    = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_MISSING = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [2:0] ST_STORED       = 3'd0;
    localparam logic [2:0] ST_COMPLETE     = 3'd1;
    localparam logic [2:0] ST_FULL         = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd3;
    localparam logic [2:0] ST_NONE_MISSING = 3'd4;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_STATUS,
        EM_SAVE,
        EM_BYTE,
        EM_MISS
    } emit_kind_t;

    typedef struct packed {
        logic       ld_item;
        logic       srch_step;
        logic       key_rd;
        logic       hit_take;
        logic       free_take;
        logic       fill_we;
        logic       save_commit;
        logic       msg_rd;
        logic       pos_clr;
        logic       pos_inc;
        logic       pos_step;
        logic       pend_set;
        logic       pend_clr;
        logic       valid_clr;
        emit_kind_t emit;
        logic [2:0] emit_code;
        logic       emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       hit;
        logic       idx_last;
        logic       free_any;
        logic       fill_last;
        logic       rd_last;
        logic       ms_go;
        logic       marker;
        logic       pend;
        logic       out_free;
    } dp_stat_t;

endpackage

[design/frb_ram.sv]
module frb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/frb_ctrl.sv]
module frb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_cmd,
    output logic              in_ready,
    input  frb_pkg::dp_stat_t stat,
    output frb_pkg::dp_cmd_t  ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_KRD,
        S_KCMP,
        S_FILL,
        S_WRITE,
        S_EMIT,
        S_RRD,
        S_RDATA,
        S_MCHK,
        S_MDATA,
        S_MEND
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= frb_pkg::ST_STORED;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        ctl        = '0;
        ctl.emit   = frb_pkg::EM_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.ld_item = 1'b1;
                    if (in_cmd != frb_pkg::CMD_UNUSED)
                    begin
                        state_next = S_KRD;
                    end
                end
            end
            S_KRD:
            begin
                ctl.key_rd = 1'b1;
                state_next = S_KCMP;
            end
            S_KCMP:
            begin
                if (stat.hit)
                begin
                    ctl.hit_take = 1'b1;
                    ctl.pos_clr  = 1'b1;
                    ctl.pend_clr = 1'b1;
                    case (stat.cmd)
                        frb_pkg::CMD_SAVE: state_next = S_WRITE;
                        frb_pkg::CMD_READ: state_next = S_RRD;
                        default:           state_next = S_MCHK;
                    endcase
                end
                else if (stat.idx_last)
                begin
                    if (stat.cmd != frb_pkg::CMD_SAVE)
                    begin
                        code_next  = frb_pkg::ST_NOT_FOUND;
                        state_next = S_EMIT;
                    end
                    else if (stat.free_any)
                    begin
                        ctl.free_take = 1'b1;
                        state_next    = S_FILL;
                    end
                    else
                    begin
                        code_next  = frb_pkg::ST_FULL;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    ctl.srch_step = 1'b1;
                    state_next    = S_KRD;
                end
            end
            S_FILL:
            begin
                ctl.fill_we = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (stat.out_free)
                begin
                    ctl.save_commit = 1'b1;
                    ctl.emit        = frb_pkg::EM_SAVE;
                    state_next      = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.emit      = frb_pkg::EM_STATUS;
                    ctl.emit_code = code_reg;
                    state_next    = S_IDLE;
                end
            end
            S_RRD:
            begin
                ctl.msg_rd = 1'b1;
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                if (stat.out_free)
                begin
                    ctl.emit = frb_pkg::EM_BYTE;
                    if (stat.rd_last)
                    begin
                        ctl.valid_clr = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        ctl.pos_inc = 1'b1;
                        state_next  = S_RRD;
                    end
                end
            end
            S_MCHK:
            begin
                if (stat.ms_go)
                begin
                    ctl.msg_rd = 1'b1;
                    state_next = S_MDATA;
                end
                else if (stat.pend)
                begin
                    state_next = S_MEND;
                end
                else
                begin
                    code_next  = frb_pkg::ST_NONE_MISSING;
                    state_next = S_EMIT;
                end
            end
            S_MDATA:
            begin
                if (!stat.marker)
                begin
                    ctl.pos_step = 1'b1;
                    state_next   = S_MCHK;
                end
                else if (!stat.pend)
                begin
                    ctl.pend_set = 1'b1;
                    ctl.pos_step = 1'b1;
                    state_next   = S_MCHK;
                end
                else if (stat.out_free)
                begin
                    ctl.emit     = frb_pkg::EM_MISS;
                    ctl.pend_set = 1'b1;
                    ctl.pos_step = 1'b1;
                    state_next   = S_MCHK;
                end
            end
            S_MEND:
            begin
                if (stat.out_free)
                begin
                    ctl.emit      = frb_pkg::EM_MISS;
                    ctl.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[design/frb_dp.sv]
module frb_dp #(
    parameter int ENTRIES   = frb_pkg::ENTRIES_DEF,
    parameter int MSG_BYTES = frb_pkg::MSG_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  frb_pkg::dp_cmd_t  ctl,
    output frb_pkg::dp_stat_t stat,
    input  logic [1:0]        cmd,
    input  logic [7:0]        src_addr,
    input  logic [7:0]        dest_addr,
    input  logic [5:0]        byte_offset,
    input  logic [7:0]        data_byte,
    input  logic              piece_last,
    input  logic [6:0]        total_length,
    input  logic [6:0]        piece_stride,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [7:0]        out_byte,
    output logic [5:0]        missing_offset,
    output logic              run_last
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = $clog2(MSG_BYTES);
    localparam int MD = ENTRIES * MSG_BYTES;
    localparam int AW = (MD > 1) ? $clog2(MD) : 1;
    localparam logic [6:0] MB7 = 7'(MSG_BYTES);
    localparam logic [7:0] MB8 = 8'(MSG_BYTES);

    logic [1:0]  cmd_reg;
    logic [15:0] key_reg;
    logic [5:0]  off_reg;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic [6:0]  total_reg;
    logic [6:0]  stride_reg;

    logic [IW-1:0] idx_reg, slot_reg, free_reg;
    logic          free_found_reg;
    logic [6:0]    count_reg;
    logic [PW-1:0] fill_reg;
    logic [7:0]    pos_reg;
    logic [5:0]    pend_off_reg;
    logic          pend_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic          out_valid_reg, run_last_reg;
    logic [2:0]    status_reg;
    logic [7:0]    out_byte_reg;
    logic [5:0]    miss_reg;

    logic          run_last_next;
    logic [2:0]    status_next;
    logic [7:0]    out_byte_next;
    logic [5:0]    miss_next;

    logic [15:0]   key_q;
    logic [6:0]    count_q;
    logic [7:0]    msg_q;
    logic [6:0]    count_new;
    logic          idx_free;
    logic          off_in;
    logic [AW-1:0] base, msg_addr;
    logic [7:0]    stride_eff;

    assign idx_free   = !valid_reg[idx_reg];
    assign count_new  = (count_reg < MB7) ? count_reg + 7'd1 : count_reg;
    assign off_in     = ({1'b0, off_reg} < MB7);
    assign stride_eff = (stride_reg == 7'd0) ? 8'd1 : {1'b0, stride_reg};
    assign base       = AW'(slot_reg) * AW'(MSG_BYTES);

    always_comb
    begin
        if (ctl.fill_we)
        begin
            msg_addr = base + AW'(fill_reg);
        end
        else if (ctl.msg_rd)
        begin
            msg_addr = base + AW'(pos_reg);
        end
        else
        begin
            msg_addr = base + AW'(off_reg);
        end
    end

    frb_ram #(.WIDTH(16), .DEPTH(ENTRIES), .AW(IW)) u_key_ram (
        .clk   (clk),
        .we    (ctl.save_commit),
        .waddr (slot_reg),
        .wdata (key_reg),
        .re    (ctl.key_rd),
        .raddr (idx_reg),
        .rdata (key_q)
    );

    frb_ram #(.WIDTH(7), .DEPTH(ENTRIES), .AW(IW)) u_count_ram (
        .clk   (clk),
        .we    (ctl.save_commit),
        .waddr (slot_reg),
        .wdata (count_new),
        .re    (ctl.key_rd),
        .raddr (idx_reg),
        .rdata (count_q)
    );

    frb_ram #(.WIDTH(8), .DEPTH(MD), .AW(AW)) u_msg_ram (
        .clk   (clk),
        .we    (ctl.fill_we || (ctl.save_commit && off_in)),
        .waddr (msg_addr),
        .wdata (ctl.fill_we ? frb_pkg::MARKER : data_reg),
        .re    (ctl.msg_rd),
        .raddr (msg_addr),
        .rdata (msg_q)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.ld_item)
        begin
            cmd_reg    <= cmd;
            key_reg    <= {src_addr, dest_addr};
            off_reg    <= byte_offset;
            data_reg   <= data_byte;
            last_reg   <= piece_last;
            total_reg  <= total_length;
            stride_reg <= piece_stride;
        end
        if (ctl.ld_item)
        begin
            idx_reg <= '0;
        end
        else if (ctl.srch_step)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
        if (ctl.srch_step && idx_free && !free_found_reg)
        begin
            free_reg <= idx_reg;
        end
        if (ctl.hit_take)
        begin
            slot_reg  <= idx_reg;
            count_reg <= count_q;
        end
        else if (ctl.free_take)
        begin
            slot_reg  <= free_found_reg ? free_reg : idx_reg;
            count_reg <= 7'd0;
        end
        if (ctl.free_take)
        begin
            fill_reg <= '0;
        end
        else if (ctl.fill_we)
        begin
            fill_reg <= fill_reg + PW'(1);
        end
        if (ctl.pos_clr)
        begin
            pos_reg <= 8'd0;
        end
        else if (ctl.pos_inc)
        begin
            pos_reg <= pos_reg + 8'd1;
        end
        else if (ctl.pos_step)
        begin
            pos_reg <= pos_reg + stride_eff;
        end
        if (ctl.pend_set)
        begin
            pend_off_reg <= pos_reg[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            free_found_reg <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.ld_item)
            begin
                free_found_reg <= 1'b0;
            end
            else if (ctl.srch_step && idx_free)
            begin
                free_found_reg <= 1'b1;
            end
            if (ctl.save_commit)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            else if (ctl.valid_clr)
            begin
                valid_reg[slot_reg] <= 1'b0;
            end
            if (ctl.pend_clr)
            begin
                pend_reg <= 1'b0;
            end
            else if (ctl.pend_set)
            begin
                pend_reg <= 1'b1;
            end
            if (ctl.emit != frb_pkg::EM_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status_next   = frb_pkg::ST_STORED;
        out_byte_next = 8'd0;
        miss_next     = 6'd0;
        run_last_next = 1'b1;
        case (ctl.emit)
            frb_pkg::EM_STATUS:
            begin
                status_next = ctl.emit_code;
            end
            frb_pkg::EM_SAVE:
            begin
                if (last_reg && (count_new == total_reg))
                begin
                    status_next = frb_pkg::ST_COMPLETE;
                end
            end
            frb_pkg::EM_BYTE:
            begin
                out_byte_next = msg_q;
                run_last_next = stat.rd_last;
            end
            frb_pkg::EM_MISS:
            begin
                miss_next     = pend_off_reg;
                run_last_next = ctl.emit_last;
            end
            default:
            begin
                status_next = frb_pkg::ST_STORED;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit != frb_pkg::EM_NONE)
        begin
            status_reg   <= status_next;
            out_byte_reg <= out_byte_next;
            miss_reg     <= miss_next;
            run_last_reg <= run_last_next;
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.hit       = !idx_free && (key_q == key_reg);
    assign stat.idx_last  = (idx_reg == IW'(ENTRIES - 1));
    assign stat.free_any  = free_found_reg || idx_free;
    assign stat.fill_last = (fill_reg == PW'(MSG_BYTES - 1));
    assign stat.rd_last   = ((pos_reg + 8'd1) == {1'b0, count_reg});
    assign stat.ms_go     = (pos_reg < {1'b0, total_reg}) && (pos_reg < MB8);
    assign stat.marker    = (msg_q == frb_pkg::MARKER);
    assign stat.pend      = pend_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign out_byte       = out_byte_reg;
    assign missing_offset = miss_reg;
    assign run_last       = run_last_reg;

endmodule

[design/fragment_reassembly_buffer.sv]
// channel  signals                                   direction
// input    in_valid/in_ready, cmd .. piece_stride    into block
// output   out_valid/out_ready, status .. run_last   out of block
//
// One item at a time. The key search reads one slot of the key/count RAMs
// per read/compare state pair, up to ENTRIES slots per command. A new slot
// is then preset with the marker, MSG_BYTES bytes, via the message RAM
// port. Read fetches and emits each byte; a missing query checks each probed
// offset. A stalled output holds the controller; reset clears the controller,
// the output valid and the entry valid bits, RAM contents stay undefined.
module fragment_reassembly_buffer #(
    parameter int ENTRIES   = frb_pkg::ENTRIES_DEF,
    parameter int MSG_BYTES = frb_pkg::MSG_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] src_addr,
    input  logic [7:0] dest_addr,
    input  logic [5:0] byte_offset,
    input  logic [7:0] data_byte,
    input  logic       piece_last,
    input  logic [6:0] total_length,
    input  logic [6:0] piece_stride,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] out_byte,
    output logic [5:0] missing_offset,
    output logic       run_last
);

    frb_pkg::dp_cmd_t  ctl;
    frb_pkg::dp_stat_t stat;

    // sequence each command: search, preset, commit, emit runs
    frb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (cmd),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // hold the item, the table RAMs and the output register
    frb_dp #(.ENTRIES(ENTRIES), .MSG_BYTES(MSG_BYTES)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cmd            (cmd),
        .src_addr       (src_addr),
        .dest_addr      (dest_addr),
        .byte_offset    (byte_offset),
        .data_byte      (data_byte),
        .piece_last     (piece_last),
        .total_length   (total_length),
        .piece_stride   (piece_stride),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .out_byte       (out_byte),
        .missing_offset (missing_offset),
        .run_last       (run_last)
    );

    // a real command makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd != frb_pkg::CMD_UNUSED) |=> !in_ready)
        else $error("block took a command without going busy");

    // every status other than stored ends its run at once
    a_single_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != frb_pkg::ST_STORED) |-> run_last)
        else $error("non-stored status without run_last");

    // a read byte never carries a missing offset
    a_byte_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_byte != 8'd0) |-> (missing_offset == 6'd0))
        else $error("byte and offset both set");

endmodule
